@@ hdl/direct_time_to_contact_macros.svh @@
// assertion macros shared by the time-to-contact checkers
`ifndef DIRECT_TIME_TO_CONTACT_MACROS_SVH
`define DIRECT_TIME_TO_CONTACT_MACROS_SVH

// property checked on every clock edge outside reset
`define DTTC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property that also covers the reset cycles
`define DTTC_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/dttc_pkg.sv @@
// shared types, constants and term tables of the time-to-contact estimator
`timescale 1ns / 1ps
package dttc_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_ROI_LEFT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROI_TOP     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROI_WIDTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROI_HEIGHT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH = 3'd4;

  localparam logic [11:0] ROI_LEFT_RST    = 12'd29;
  localparam logic [11:0] ROI_TOP_RST     = 12'd0;
  localparam logic [8:0]  ROI_WIDTH_RST   = 9'd133;
  localparam logic [12:0] ROI_HEIGHT_RST  = 13'd70;
  localparam logic [12:0] FRAME_WIDTH_RST = 13'd640;

  // status codes
  localparam logic [1:0] ST_VALID    = 2'd0;
  localparam logic [1:0] ST_SINGULAR = 2'd1;
  localparam logic [1:0] ST_ZERO_DIV = 2'd2;

  // accumulated sums: 0..5 normal matrix, 6..8 right-hand vector
  localparam int NUM_SUMS = 9;
  localparam int SUM_W    = 64;
  typedef logic [NUM_SUMS-1:0][SUM_W-1:0] sums_t;

  // weighted gradient width and determinant width
  localparam int GW    = 25;
  localparam int DET_W = 194;

  // frames of sums waiting between front and solver
  localparam int QUEUE_DEPTH = 2;

  // sum index of operand k of determinant term t (terms 6..11 use the B column)
  function automatic logic [3:0] term_src(input logic [3:0] t, input logic [1:0] k);
    logic        alt;
    logic [3:0]  tt;
    logic [11:0] trip;
    logic [3:0]  e;
    logic [3:0]  s;
    alt = (t >= 4'd6);
    tt  = alt ? t - 4'd6 : t;
    case (tt)
      4'd0:    trip = {4'd0, 4'd4, 4'd8};
      4'd1:    trip = {4'd1, 4'd5, 4'd6};
      4'd2:    trip = {4'd2, 4'd3, 4'd7};
      4'd3:    trip = {4'd2, 4'd4, 4'd6};
      4'd4:    trip = {4'd0, 4'd5, 4'd7};
      4'd5:    trip = {4'd1, 4'd3, 4'd8};
      default: trip = '0;
    endcase
    case (k)
      2'd0:    e = trip[11:8];
      2'd1:    e = trip[7:4];
      default: e = trip[3:0];
    endcase
    case (e)
      4'd0:    s = 4'd0;
      4'd1:    s = 4'd1;
      4'd2:    s = alt ? 4'd6 : 4'd2;
      4'd3:    s = 4'd1;
      4'd4:    s = 4'd3;
      4'd5:    s = alt ? 4'd7 : 4'd4;
      4'd6:    s = 4'd2;
      4'd7:    s = 4'd4;
      4'd8:    s = alt ? 4'd8 : 4'd5;
      default: s = 4'd0;
    endcase
    return s;
  endfunction

  // anti-diagonal terms of the expansion are subtracted
  function automatic logic term_neg(input logic [3:0] t);
    logic [3:0] tt;
    tt = (t >= 4'd6) ? t - 4'd6 : t;
    return (tt >= 4'd3);
  endfunction

endpackage

@@ hdl/dttc_fifo.sv @@
// short queue of per-frame sums between the pixel front end and the solver
`timescale 1ns / 1ps
module dttc_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  dttc_pkg::sums_t din,
  output logic           full,
  input  logic           pop,
  output dttc_pkg::sums_t dout,
  output logic           empty
);
  import dttc_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  sums_t           entry [QUEUE_DEPTH];
  logic [PW-1:0]   wp;
  logic [PW-1:0]   rp;
  logic [PW:0]     count;
  logic            do_push;
  logic            do_pop;

  assign full    = (count == (PW+1)'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = entry[rp];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) entry[wp] <= din;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (do_push) wp <= (wp == PW'(QUEUE_DEPTH-1)) ? '0 : wp + PW'(1);
      if (do_pop)  rp <= (rp == PW'(QUEUE_DEPTH-1)) ? '0 : rp + PW'(1);
      if (do_push && !do_pop)      count <= count + (PW+1)'(1);
      else if (do_pop && !do_push) count <= count - (PW+1)'(1);
    end
  end

endmodule

@@ hdl/dttc_front.sv @@
// pixel front end: roi crop, line buffer, gradients and sum accumulation
`timescale 1ns / 1ps
module dttc_front #(
  parameter int MAX_ROI_WIDTH = 256
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [dttc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dttc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           push,
  output logic                           full,
  input  logic [7:0]                     pixel_first,
  input  logic [7:0]                     pixel_second,
  input  logic                           end_of_frame,
  output logic                           q_push,
  output dttc_pkg::sums_t                q_data,
  input  logic                           q_full
);
  import dttc_pkg::*;

  localparam int          CW     = $clog2(MAX_ROI_WIDTH);
  localparam int          LDEPTH = 2 ** CW;
  localparam logic [12:0] MAX_W  = 13'(MAX_ROI_WIDTH);

  // configuration registers
  logic [11:0] roi_left;
  logic [11:0] roi_top;
  logic [8:0]  roi_width;
  logic [12:0] roi_height;
  logic [12:0] frame_width;

  always_ff @(posedge clk) begin
    if (rst) begin
      roi_left    <= ROI_LEFT_RST;
      roi_top     <= ROI_TOP_RST;
      roi_width   <= ROI_WIDTH_RST;
      roi_height  <= ROI_HEIGHT_RST;
      frame_width <= FRAME_WIDTH_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ROI_LEFT:    roi_left    <= cfg_data[11:0];
        REG_ROI_TOP:     roi_top     <= cfg_data[11:0];
        REG_ROI_WIDTH:   roi_width   <= cfg_data[8:0];
        REG_ROI_HEIGHT:  roi_height  <= cfg_data;
        REG_FRAME_WIDTH: frame_width <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline control: only a frame result blocked by the queue stalls
  logic adv;
  logic accept;
  logic p_valid;
  logic p_eof;

  assign adv    = !(p_valid && p_eof && q_full);
  assign full   = !adv;
  assign accept = push && adv;

  // frame position and roi decode
  logic [11:0] row_count;
  logic [11:0] col_count;
  logic [12:0] fw;
  logic [12:0] rw;
  logic [11:0] r_off;
  logic [11:0] c_off;
  logic        in_roi;
  logic        is_last;
  logic        c_nz;
  logic        acc_pos;
  logic [CW-1:0] ci;

  assign fw = (frame_width == 13'd0 || frame_width > 13'd4096) ? 13'd4096 : frame_width;
  assign rw = (13'(roi_width) > MAX_W) ? MAX_W : 13'(roi_width);
  assign r_off = row_count - roi_top;
  assign c_off = col_count - roi_left;
  assign in_roi = (row_count >= roi_top) && (col_count >= roi_left) &&
                  ({1'b0, r_off} < roi_height) && ({1'b0, c_off} < rw);
  assign is_last = ({1'b0, c_off} == rw - 13'd1) || ({1'b0, col_count} == fw - 13'd1);
  assign c_nz = (c_off != 12'd0);
  assign acc_pos = in_roi && (r_off >= 12'd2) && (c_off >= 12'd2);
  assign ci = c_off[CW-1:0];

  // raster counters
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
    end else if (accept) begin
      if (end_of_frame) begin
        row_count <= '0;
        col_count <= '0;
      end else if ({1'b0, col_count} + 13'd1 >= fw) begin
        col_count <= '0;
        row_count <= row_count + 12'd1;
      end else begin
        col_count <= col_count + 12'd1;
      end
    end
  end

  // previous roi pixel of the current row
  logic [7:0] left_first;
  logic [7:0] left_second;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_first  <= '0;
      left_second <= '0;
    end else if (accept && in_roi) begin
      left_first  <= pixel_first;
      left_second <= pixel_second;
    end
  end

  // line buffer: both frames in one word, last column written in the following cycle
  logic [15:0]     line_mem [LDEPTH];
  logic [LDEPTH-1:0] line_vld;
  logic [15:0]     line_rd;
  logic            line_rd_vld;
  logic            mem_we;
  logic [CW-1:0]   mem_wa;
  logic [15:0]     mem_wd;
  logic            pend_valid;
  logic [CW-1:0]   pend_addr;
  logic [15:0]     pend_data;

  always_comb begin
    mem_we = 1'b0;
    mem_wa = ci;
    mem_wd = {pixel_first, pixel_second};
    if (pend_valid) begin
      mem_we = 1'b1;
      mem_wa = pend_addr;
      mem_wd = pend_data;
    end else if (accept && in_roi) begin
      if (c_nz) begin
        mem_we = 1'b1;
        mem_wa = ci - CW'(1);
        mem_wd = {left_first, left_second};
      end else if (is_last) begin
        mem_we = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) line_mem[mem_wa] <= mem_wd;
    if (accept) line_rd <= line_mem[ci];
    pend_addr <= ci;
    pend_data <= {pixel_first, pixel_second};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_vld    <= '0;
      line_rd_vld <= 1'b0;
      pend_valid  <= 1'b0;
    end else begin
      if (accept) line_rd_vld <= line_vld[ci];
      if (mem_we) line_vld[mem_wa] <= 1'b1;
      pend_valid <= accept && in_roi && c_nz && is_last;
    end
  end

  // stage 1: item waiting for line buffer data
  logic        s_valid;
  logic        s_eof;
  logic        s_roi;
  logic        s_acc;
  logic [7:0]  s_p1;
  logic [7:0]  s_p2;
  logic [7:0]  s_l1;
  logic [7:0]  s_l2;
  logic [11:0] s_cm1;
  logic [11:0] s_rm1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (adv) begin
      s_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s_eof <= end_of_frame;
      s_roi <= in_roi;
      s_acc <= acc_pos;
      s_p1  <= pixel_first;
      s_p2  <= pixel_second;
      s_l1  <= left_first;
      s_l2  <= left_second;
      s_cm1 <= c_off - 12'd1;
      s_rm1 <= r_off - 12'd1;
    end
  end

  // 2x2 gradients; upper-left is the upper pixel read by the previous roi item
  logic [7:0] u1;
  logic [7:0] u2;
  logic [7:0] ul1;
  logic [7:0] ul2;
  logic signed [10:0] drow_c;
  logic signed [10:0] dcol_c;
  logic signed [10:0] dt_c;

  assign u1 = line_rd_vld ? line_rd[15:8] : 8'd0;
  assign u2 = line_rd_vld ? line_rd[7:0]  : 8'd0;
  assign drow_c = 11'(s_l1) + 11'(s_p1) - 11'(ul1) - 11'(u1)
                + 11'(s_l2) + 11'(s_p2) - 11'(ul2) - 11'(u2);
  assign dcol_c = 11'(u1) + 11'(s_p1) - 11'(ul1) - 11'(s_l1)
                + 11'(u2) + 11'(s_p2) - 11'(ul2) - 11'(s_l2);
  assign dt_c = 11'(ul2) + 11'(u2) + 11'(s_l2) + 11'(s_p2)
              - 11'(ul1) - 11'(u1) - 11'(s_l1) - 11'(s_p1);

  always_ff @(posedge clk) begin
    if (adv && s_valid && s_roi) begin
      ul1 <= u1;
      ul2 <= u2;
    end
  end

  // stage 2: gradients
  logic               d_valid;
  logic               d_eof;
  logic               d_acc;
  logic signed [10:0] d_row;
  logic signed [10:0] d_col;
  logic signed [10:0] d_t;
  logic [11:0]        d_cm1;
  logic [11:0]        d_rm1;

  // stage 3: position weighted partial products
  logic               m_valid;
  logic               m_eof;
  logic               m_acc;
  logic signed [10:0] m_row;
  logic signed [10:0] m_col;
  logic signed [10:0] m_t;
  logic signed [23:0] m_pc;
  logic signed [23:0] m_pr;

  // stage 4: weighted gradient
  logic               g_valid;
  logic               g_eof;
  logic               g_acc;
  logic signed [10:0] g_row;
  logic signed [10:0] g_col;
  logic signed [10:0] g_t;
  logic signed [GW-1:0] g_g;

  // stage 5: products
  logic  p_acc;
  sums_t p_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
      m_valid <= 1'b0;
      g_valid <= 1'b0;
      p_valid <= 1'b0;
    end else if (adv) begin
      d_valid <= s_valid;
      m_valid <= d_valid;
      g_valid <= m_valid;
      p_valid <= g_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_eof <= s_eof;
      d_acc <= s_acc;
      d_row <= drow_c;
      d_col <= dcol_c;
      d_t   <= dt_c;
      d_cm1 <= s_cm1;
      d_rm1 <= s_rm1;

      m_eof <= d_eof;
      m_acc <= d_acc;
      m_row <= d_row;
      m_col <= d_col;
      m_t   <= d_t;
      m_pc  <= 24'($signed({1'b0, d_cm1}) * d_col);
      m_pr  <= 24'($signed({1'b0, d_rm1}) * d_row);

      g_eof <= m_eof;
      g_acc <= m_acc;
      g_row <= m_row;
      g_col <= m_col;
      g_t   <= m_t;
      g_g   <= GW'(m_pc) + GW'(m_pr);

      p_eof     <= g_eof;
      p_acc     <= g_acc;
      p_prod[0] <= 64'(g_row * g_row);
      p_prod[1] <= 64'(g_row * g_col);
      p_prod[2] <= 64'(g_row * g_g);
      p_prod[3] <= 64'(g_col * g_col);
      p_prod[4] <= 64'(g_col * g_g);
      p_prod[5] <= 64'(g_g * g_g);
      p_prod[6] <= 64'(g_row * g_t);
      p_prod[7] <= 64'(g_col * g_t);
      p_prod[8] <= 64'(g_g * g_t);
    end
  end

  // accumulation; a frame's totals leave on its last pair
  sums_t sums;
  sums_t sums_plus;

  always_comb begin
    for (int i = 0; i < NUM_SUMS; i++) begin
      sums_plus[i] = sums[i] + (p_acc ? p_prod[i] : '0);
    end
  end

  assign q_data = sums_plus;
  assign q_push = adv && p_valid && p_eof;

  always_ff @(posedge clk) begin
    if (rst) begin
      sums <= '0;
    end else if (adv && p_valid) begin
      if (p_eof) sums <= '0;
      else       sums <= sums_plus;
    end
  end

endmodule

@@ hdl/dttc_solver.sv @@
// per-frame solver: cramer determinants on a shared 32x32 multiplier, bit-serial divide
`timescale 1ns / 1ps
module dttc_solver #(
  parameter int FRAC_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_empty,
  input  dttc_pkg::sums_t      q_data,
  output logic                 q_pop,
  input  logic                 pop,
  output logic                 empty,
  output logic signed [31:0]   time_to_contact,
  output logic [1:0]           status
);
  import dttc_pkg::*;

  localparam int DW   = DET_W;
  localparam int MW   = DW - 1;
  localparam int NUMW = MW + FRAC_BITS + 2;
  localparam int CNTW = $clog2(NUMW);

  typedef enum logic [11:0] {
    S_IDLE = 12'b000000000001,
    S_OPA  = 12'b000000000010,
    S_OPB  = 12'b000000000100,
    S_MUL  = 12'b000000001000,
    S_ACC  = 12'b000000010000,
    S_OPC  = 12'b000000100000,
    S_TERM = 12'b000001000000,
    S_MAGS = 12'b000010000000,
    S_NUM  = 12'b000100000000,
    S_DIV  = 12'b001000000000,
    S_SAT  = 12'b010000000000,
    S_DONE = 12'b100000000000
  } state_t;

  state_t state;

  sums_t                sums_r;
  logic [3:0]           t;
  logic                 sgn;
  logic [127:0]         a_reg;
  logic [63:0]          b_reg;
  logic [191:0]         prod;
  logic [63:0]          mreg;
  logic [1:0]           li;
  logic                 lj;
  logic                 second;
  logic signed [DW-1:0] da;
  logic signed [DW-1:0] dc;
  logic [MW-1:0]        mag_da;
  logic [MW-1:0]        mag_dc;
  logic [NUMW-1:0]      num;
  logic [DW-1:0]        den;
  logic [DW:0]          rem;
  logic [CNTW-1:0]      cnt;
  logic [31:0]          qv;
  logic                 big;
  logic                 neg;
  logic [31:0]          fin_ttc;
  logic [1:0]           fin_status;
  logic                 res_valid;

  // operand fetch: one sum read per cycle
  logic [1:0]  k;
  logic [63:0] opnd;
  logic [63:0] opnd_mag;

  always_comb begin
    k = 2'd0;
    if (state == S_OPB)      k = 2'd1;
    else if (state == S_OPC) k = 2'd2;
  end

  assign opnd     = sums_r[term_src(t, k)];
  assign opnd_mag = opnd[63] ? (~opnd + 64'd1) : opnd;

  // limb step of the multiplier
  logic [2:0]   lsh;
  logic         last_step;
  logic         tneg;
  logic [DW-1:0] prod_ext;

  assign lsh       = 3'(li) + 3'(lj);
  assign last_step = lj && (li == (second ? 2'd3 : 2'd1));
  assign tneg      = sgn ^ term_neg(t);
  assign prod_ext  = DW'(prod);

  // restoring divide step
  logic [DW:0] remsh;
  logic        ge;

  assign remsh = {rem[DW-1:0], num[NUMW-1]};
  assign ge    = (remsh >= {1'b0, den});

  // result register
  assign empty = !res_valid;
  assign q_pop = (state == S_IDLE) && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      if (pop && res_valid) res_valid <= 1'b0;
      if (state == S_DONE && !res_valid) res_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && !res_valid) begin
      time_to_contact <= fin_ttc;
      status          <= fin_status;
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: if (!q_empty) state <= S_OPA;
        S_OPA:  state <= S_OPB;
        S_OPB:  state <= S_MUL;
        S_MUL:  state <= S_ACC;
        S_ACC: begin
          if (!last_step)  state <= S_MUL;
          else if (second) state <= S_TERM;
          else             state <= S_OPC;
        end
        S_OPC:  state <= S_MUL;
        S_TERM: state <= (t == 4'd11) ? S_MAGS : S_OPA;
        S_MAGS: state <= (da == '0 || dc == '0) ? S_DONE : S_NUM;
        S_NUM:  state <= S_DIV;
        S_DIV:  if (cnt == '0) state <= S_SAT;
        S_SAT:  state <= S_DONE;
        S_DONE: if (!res_valid) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        sums_r <= q_data;
        t      <= '0;
        da     <= '0;
        dc     <= '0;
      end
      S_OPA: begin
        a_reg <= 128'(opnd_mag);
        sgn   <= opnd[63];
      end
      S_OPB: begin
        b_reg  <= opnd_mag;
        sgn    <= sgn ^ opnd[63];
        prod   <= '0;
        li     <= '0;
        lj     <= 1'b0;
        second <= 1'b0;
      end
      S_MUL: begin
        mreg <= 64'(a_reg[32*li +: 32]) * 64'(b_reg[32*lj +: 32]);
      end
      S_ACC: begin
        prod <= prod + (192'(mreg) << {lsh, 5'd0});
        if (lj) begin
          lj <= 1'b0;
          li <= li + 2'd1;
        end else begin
          lj <= 1'b1;
        end
      end
      S_OPC: begin
        a_reg  <= prod[127:0];
        b_reg  <= opnd_mag;
        sgn    <= sgn ^ opnd[63];
        prod   <= '0;
        li     <= '0;
        lj     <= 1'b0;
        second <= 1'b1;
      end
      S_TERM: begin
        if (t < 4'd6) da <= tneg ? da - $signed(prod_ext) : da + $signed(prod_ext);
        else          dc <= tneg ? dc - $signed(prod_ext) : dc + $signed(prod_ext);
        t <= t + 4'd1;
      end
      S_MAGS: begin
        fin_ttc    <= '0;
        fin_status <= (da == '0) ? ST_SINGULAR : ST_ZERO_DIV;
        neg        <= (da[DW-1] == dc[DW-1]);
        mag_da     <= da[DW-1] ? MW'(-da) : MW'(da);
        mag_dc     <= dc[DW-1] ? MW'(-dc) : MW'(dc);
      end
      S_NUM: begin
        num <= (NUMW'(mag_da) << (FRAC_BITS + 1)) + NUMW'(mag_dc);
        den <= {mag_dc, 1'b0};
        rem <= '0;
        qv  <= '0;
        big <= 1'b0;
        cnt <= CNTW'(NUMW - 1);
      end
      S_DIV: begin
        rem <= ge ? remsh - {1'b0, den} : remsh;
        num <= num << 1;
        qv  <= {qv[30:0], ge};
        big <= big | qv[31];
        cnt <= cnt - CNTW'(1);
      end
      S_SAT: begin
        fin_status <= ST_VALID;
        if (!neg) fin_ttc <= (big || qv > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : qv;
        else      fin_ttc <= (big || qv > 32'h8000_0000) ? 32'h8000_0000 : (32'd0 - qv);
      end
      default: ;
    endcase
  end

endmodule

@@ hdl/direct_time_to_contact.sv @@
// Direct time-to-contact estimator. Pixel pairs enter at one per clock while full is low,
// through a front end (roi crop, line buffer, 2x2 gradients, weighting, products, sums); full
// rises only when a frame's sums cannot enter the two-frame queue to the solver. The solver
// works through twelve determinant terms on one shared 32x32 multiplier, then a
// one-bit-per-cycle restoring divide. Line buffer valid bits are cleared by reset directly:
// there is no clearing pass. One result is held until popped while the next frame is
// already being solved.
`timescale 1ns / 1ps
module direct_time_to_contact #(
  parameter int MAX_ROI_WIDTH = 256,
  parameter int FRAC_BITS     = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [dttc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dttc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           push,
  output logic                           full,
  input  logic [7:0]                     pixel_first,
  input  logic [7:0]                     pixel_second,
  input  logic                           end_of_frame,
  output logic                           empty,
  input  logic                           pop,
  output logic signed [31:0]             time_to_contact,
  output logic [1:0]                     status
);
  import dttc_pkg::*;

  logic  q_push;
  logic  q_full;
  logic  q_pop;
  logic  q_empty;
  sums_t q_din;
  sums_t q_dout;

  // pixel front end
  dttc_front #(
    .MAX_ROI_WIDTH(MAX_ROI_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .push         (push),
    .full         (full),
    .pixel_first  (pixel_first),
    .pixel_second (pixel_second),
    .end_of_frame (end_of_frame),
    .q_push       (q_push),
    .q_data       (q_din),
    .q_full       (q_full)
  );

  // frame sums queue
  dttc_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  // solver and result register
  dttc_solver #(
    .FRAC_BITS(FRAC_BITS)
  ) u_solver (
    .clk             (clk),
    .rst             (rst),
    .q_empty         (q_empty),
    .q_data          (q_dout),
    .q_pop           (q_pop),
    .pop             (pop),
    .empty           (empty),
    .time_to_contact (time_to_contact),
    .status          (status)
  );

endmodule

@@ hdl/dttc_checker.sv @@
// port-level checks of the time-to-contact estimator, bound to the top level
`timescale 1ns / 1ps
`include "direct_time_to_contact_macros.svh"
module dttc_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           full,
  input logic                           empty,
  input logic                           pop,
  input logic signed [31:0]             time_to_contact,
  input logic [1:0]                     status
);
  import dttc_pkg::*;

  // reset leaves no result and an open input
  `DTTC_ASSERT_RST(a_reset_empty, rst |=> empty, "result pending after reset")
  `DTTC_ASSERT_RST(a_reset_open, rst |=> !full, "input blocked after reset")

  // an unpopped result stays put
  `DTTC_ASSERT(a_hold, !empty && !pop |=> !empty && $stable(time_to_contact) && $stable(status), "result changed before pop")

  // status is one of the defined codes
  `DTTC_ASSERT(a_status_code, !empty |-> status == ST_VALID || status == ST_SINGULAR || status == ST_ZERO_DIV, "undefined status")

  // failed solves report zero time
  `DTTC_ASSERT(a_fail_zero, !empty && status != ST_VALID |-> time_to_contact == 32'sd0, "nonzero time on failed solve")

endmodule

bind direct_time_to_contact dttc_checker u_checker (.*);
